>>> rtl/hlsc_pkg.sv
`timescale 1ns / 1ps
// Package for the HTTP last status code parser.
// Holds the shared field widths, character constants and the result struct.
package hlsc_pkg;

  localparam int ByteW = 8;
  localparam int CodeW = 10;

  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChH     = 8'h48;
  localparam logic [ByteW-1:0] ChT     = 8'h54;
  localparam logic [ByteW-1:0] ChP     = 8'h50;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;

  // One finished parse: the status flag and the code.
  typedef struct packed {
    logic             status_valid;
    logic [CodeW-1:0] status_code;
  } result_t;

endpackage

>>> rtl/hlsc_scan.sv
`timescale 1ns / 1ps
// Per-byte scan state of the parser: "HTTP/" matcher, phase, digit accumulator.
// Depends on hlsc_pkg.
module hlsc_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [hlsc_pkg::ByteW-1:0]  byte_req,
  input  logic                        last,
  output hlsc_pkg::result_t           result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_DIGITS,
    PH_DONE,
    PH_FAILED
  } phase_t;

  logic [2:0]                 pattern_r, pattern_nxt;
  phase_t                     phase_r, phase_nxt;
  logic [1:0]                 digits_r, digits_nxt;
  logic [hlsc_pkg::CodeW-1:0] acc_r, acc_nxt;
  logic                       ended_r, ended_nxt;

  logic [hlsc_pkg::ByteW-1:0] want;
  logic [2:0]                 p_cur;
  logic                       is_digit;
  logic [13:0]                acc_wide;

  always_comb begin
    p_cur = (pattern_r > 3'd4) ? 3'd0 : pattern_r;
    case (p_cur)
      3'd0:    want = hlsc_pkg::ChH;
      3'd1:    want = hlsc_pkg::ChT;
      3'd2:    want = hlsc_pkg::ChT;
      3'd3:    want = hlsc_pkg::ChP;
      default: want = hlsc_pkg::ChSlash;
    endcase
    is_digit = (byte_req >= hlsc_pkg::ChZero) && (byte_req <= hlsc_pkg::ChNine);
    // acc * 10 + digit, kept to the code width.
    acc_wide = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
             + {10'd0, 4'(byte_req - hlsc_pkg::ChZero)};

    pattern_nxt = pattern_r;
    phase_nxt   = phase_r;
    digits_nxt  = digits_r;
    acc_nxt     = acc_r;
    ended_nxt   = ended_r;

    if (!ended_r) begin
      if (byte_req == hlsc_pkg::ChNul) begin
        ended_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_SPACE: begin
            if (byte_req == hlsc_pkg::ChSpace) begin
              phase_nxt  = PH_DIGITS;
              digits_nxt = 2'd0;
              acc_nxt    = '0;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              acc_nxt = acc_wide[hlsc_pkg::CodeW-1:0];
              if (digits_r >= 2'd2) begin
                phase_nxt = PH_DONE;
              end else begin
                digits_nxt = digits_r + 2'd1;
              end
            end else begin
              phase_nxt = PH_FAILED;
            end
          end
          default: begin
          end
        endcase

        // A completed "HTTP/" restarts the scan; a mismatch may begin a new match on 'H'.
        if (byte_req == want) begin
          if (p_cur == 3'd4) begin
            phase_nxt   = PH_SPACE;
            digits_nxt  = 2'd0;
            acc_nxt     = '0;
            pattern_nxt = 3'd0;
          end else begin
            pattern_nxt = p_cur + 3'd1;
          end
        end else begin
          pattern_nxt = (byte_req == hlsc_pkg::ChH) ? 3'd1 : 3'd0;
        end
      end
    end

    result.status_valid = (phase_nxt == PH_DONE);
    result.status_code  = (phase_nxt == PH_DONE) ? acc_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= 3'd0;
      phase_r   <= PH_IDLE;
      digits_r  <= 2'd0;
      acc_r     <= '0;
      ended_r   <= 1'b0;
    end else if (step) begin
      if (last) begin
        pattern_r <= 3'd0;
        phase_r   <= PH_IDLE;
        digits_r  <= 2'd0;
        acc_r     <= '0;
        ended_r   <= 1'b0;
      end else begin
        pattern_r <= pattern_nxt;
        phase_r   <= phase_nxt;
        digits_r  <= digits_nxt;
        acc_r     <= acc_nxt;
        ended_r   <= ended_nxt;
      end
    end
  end

endmodule

>>> rtl/hlsc_out_stage.sv
`timescale 1ns / 1ps
// Result register of the parser with its valid/ready handshake.
// Depends on hlsc_pkg.
module hlsc_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  hlsc_pkg::result_t           result,
  output logic                        slot_free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status_valid,
  output logic [hlsc_pkg::CodeW-1:0]  out_status_code
);

  logic              valid_r;
  hlsc_pkg::result_t data_r;

  assign slot_free        = !valid_r || out_ready;
  assign out_valid        = valid_r;
  assign out_status_valid = data_r.status_valid;
  assign out_status_code  = data_r.status_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

>>> rtl/http_last_status_code_parser_top.sv
`timescale 1ns / 1ps
// Top level of the HTTP last status code parser.
// Depends on hlsc_pkg, hlsc_scan and hlsc_out_stage.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_byte_req, in_last | sink
//   out     | out_valid, out_ready, out_status_valid,  | source
//           | out_status_code                          |
//
// Each transaction on the input channel carries one response byte. It is held
// in an input register until the scanner takes it, then scanned by the parse
// state; a byte marked last loads its result into the output register.
// A new byte can be taken every cycle unless a byte marked last waits on a
// stalled output register, so the sustained rate is one byte per clock.
// Reset (rst_n low, synchronous) clears the parse state and both valid flags.
// A stalled output only holds back a byte marked last; other bytes keep
// flowing, and the output register keeps taking results while one is taken.
module http_last_status_code_parser_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hlsc_pkg::ByteW-1:0]  in_byte_req,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status_valid,
  output logic [hlsc_pkg::CodeW-1:0]  out_status_code
);

  // Input register: holds one byte transaction until the scanner takes it.
  logic                       in_v_r;
  logic [hlsc_pkg::ByteW-1:0] byte_r;
  logic                       last_r;

  logic              slot_free;
  logic              advance;
  hlsc_pkg::result_t result;

  // A byte advances when it yields no result, or the output register can take it.
  assign advance  = in_v_r && (!last_r || slot_free);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte_req;
      last_r <= in_last;
    end
  end

  hlsc_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .byte_req (byte_r),
    .last     (last_r),
    .result   (result)
  );

  // Only a byte marked last produces a result transaction.
  hlsc_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (advance && last_r),
    .result           (result),
    .slot_free        (slot_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status_valid (out_status_valid),
    .out_status_code  (out_status_code)
  );

endmodule
